[rtl/dwis_pkg.sv]
// Shared constants for the dual-wheel integral speed controller.
package dwis_pkg;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_RIGHT_EDGE = 2'd0;
  localparam logic [1:0] REQ_LEFT_EDGE  = 2'd1;
  localparam logic [1:0] REQ_TICK       = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TARGET_LEFT  = 3'd0;
  localparam logic [2:0] CFG_TARGET_RIGHT = 3'd1;
  localparam logic [2:0] CFG_LOOP_GAIN    = 3'd2;
  localparam logic [2:0] CFG_INITIAL_DUTY = 3'd3;
  localparam logic [2:0] CFG_DUTY_MIN     = 3'd4;
  localparam logic [2:0] CFG_DUTY_MAX     = 3'd5;
  localparam logic [2:0] CFG_RUN_LIMIT    = 3'd6;

  // Register reset values.
  localparam logic [15:0] TARGET_RST       = 16'd120;
  localparam logic [15:0] LOOP_GAIN_RST    = 16'd15360;
  localparam logic [13:0] INITIAL_DUTY_RST = 14'd7500;
  localparam logic [13:0] DUTY_MIN_RST     = 14'd2;
  localparam logic [13:0] DUTY_MAX_RST     = 14'd14998;
  localparam logic [15:0] RUN_LIMIT_RST    = 16'd1000;

  // Speed scaling and saturation.
  localparam int unsigned SPEED_NUM_DEF = 2000000;
  localparam logic [20:0] SPEED_MAX     = 21'd2097151;

  // Datapath widths.
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned DUTY_W  = 14;
  localparam int unsigned SPEED_W = 21;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned PROD_W  = SPEED_W + GAIN_W;

endpackage

[rtl/dual_wheel_integral_speed_control_top.sv]
// Top level of the dual-wheel integral speed controller.
//
// Usage: the input channel (in_valid / in_stall) carries requests. A right or
// left edge request stores the wraparound timestamp difference as that
// wheel's period and completes in the cycle it is accepted; it gives no
// result. A control tick produces one result transaction on the output
// channel (out_valid / out_stall) with both duties, both speeds and the
// stopped flag. The user must write the configuration registers through
// cfg_wr_en, cfg_addr and cfg_wdata only while the block is idle; the block
// does not enforce this. Writing initial_duty also loads both integrators.
// A tick is taken through one shared bit-serial divider (one quotient bit a
// cycle, one pass per wheel, skipped for a zero period) and one shift-add
// multiplier (one gain bit a cycle, one pass per wheel); when stopped the
// multiplies are skipped.
// A finished result waits in the output register while out_stall is high;
// edges are still accepted meanwhile, and a following tick holds its result
// until the register is free.
// Reset (synchronous, active low) restores register defaults, clears the
// periods, timestamps, tick count and stop flag, and loads both integrators.
module dual_wheel_integral_speed_control_top
  import dwis_pkg::*;
#(
  parameter int unsigned SPEED_NUMERATOR = SPEED_NUM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [TIME_W-1:0]    in_edge_time,
  input  logic                 in_bump,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DUTY_W-1:0]    out_duty_left,
  output logic [DUTY_W-1:0]    out_duty_right,
  output logic [SPEED_W-1:0]   out_speed_left,
  output logic [SPEED_W-1:0]   out_speed_right,
  output logic                 out_stopped,
  // Configuration write port
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata
);

  // Quotient width follows the numerator; the counter covers both loops.
  localparam int unsigned NW = $clog2(SPEED_NUMERATOR + 1);
  localparam int unsigned STEPS_MAX = (NW > GAIN_W) ? NW : GAIN_W;
  localparam int unsigned CW = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1;
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(GAIN_W - 1);
  localparam logic [NW-1:0] NUM_VAL  = NW'(SPEED_NUMERATOR);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DLOAD = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SPD   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic                sel_r, sel_nxt;      // 0 left wheel, 1 right wheel
  logic                bump_r, bump_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  logic [NW-1:0]       q_r, q_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0]   dvs_r, dvs_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SPEED_W-1:0]  mag_r, mag_nxt;
  logic                neg_r, neg_nxt;

  logic [SPEED_W-1:0]  speed_l_r, speed_l_nxt, speed_r_r, speed_r_nxt;
  logic [DUTY_W-1:0]   integ_l_r, integ_l_nxt, integ_r_r, integ_r_nxt;
  logic [15:0]         tick_r, tick_nxt;
  logic                halted_r, halted_nxt;
  logic [TIME_W-1:0]   period_l_r, period_l_nxt, period_r_r, period_r_nxt;
  logic [TIME_W-1:0]   last_l_r, last_l_nxt, last_r_r, last_r_nxt;

  logic [15:0]         tgt_l_r, tgt_l_nxt, tgt_r_r, tgt_r_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [DUTY_W-1:0]   init_r, init_nxt, dmin_r, dmin_nxt, dmax_r, dmax_nxt;
  logic [15:0]         limit_r, limit_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]   o_duty_l_r, o_duty_l_nxt, o_duty_r_r, o_duty_r_nxt;
  logic [SPEED_W-1:0]  o_spd_l_r, o_spd_l_nxt, o_spd_r_r, o_spd_r_nxt;
  logic                o_stop_r, o_stop_nxt;

  // Datapath terms.
  logic                in_fire;
  logic                out_free;
  logic [TIME_W:0]     div_trial;
  logic                div_ge;
  logic [TIME_W:0]     div_diff;
  logic [SPEED_W-1:0]  spd_sat;
  logic [SPEED_W-1:0]  tgt_ext;
  logic                err_neg;
  logic [SPEED_W:0]    mul_sum;
  logic [PROD_W-11:0]  q_mag;
  logic signed [29:0]  q_signed;
  logic [DUTY_W-1:0]   integ_cur;
  logic signed [29:0]  u_sum;
  logic [DUTY_W-1:0]   u_clamp;
  logic [15:0]         tick_inc;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // One restoring division step: bring in the next numerator bit.
  assign div_trial = {rem_r, q_r[NW-1]};
  assign div_ge    = (div_trial >= {1'b0, dvs_r});
  assign div_diff  = div_trial - {1'b0, dvs_r};

  // Saturated speed and the magnitude and sign of the speed error.
  assign spd_sat = (32'(q_r) > 32'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(q_r);
  assign tgt_ext = SPEED_W'(sel_r ? tgt_r_r : tgt_l_r);
  assign err_neg = (spd_sat > tgt_ext);

  // One shift-add multiplication step on the low gain bit.
  assign mul_sum = {1'b0, prod_r[PROD_W-1:GAIN_W]} +
                   (prod_r[0] ? {1'b0, mag_r} : {(SPEED_W + 1){1'b0}});

  // Integrator update: product / 1024 truncated toward zero, then clamp.
  assign q_mag     = prod_r[PROD_W-1:10];
  assign q_signed  = neg_r ? -$signed(30'(q_mag)) : $signed(30'(q_mag));
  assign integ_cur = sel_r ? integ_r_r : integ_l_r;
  assign u_sum     = $signed(30'(integ_cur)) + q_signed;
  assign tick_inc  = tick_r + 16'd1;

  always_comb begin
    if (u_sum > $signed(30'(dmax_r))) begin
      u_clamp = dmax_r;
    end else if (u_sum < $signed(30'(dmin_r))) begin
      u_clamp = dmin_r;
    end else begin
      u_clamp = u_sum[DUTY_W-1:0];
    end
  end

  // Sequencer and next-state values.
  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    bump_nxt     = bump_r;
    cnt_nxt      = cnt_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    prod_nxt     = prod_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    speed_l_nxt  = speed_l_r;
    speed_r_nxt  = speed_r_r;
    integ_l_nxt  = integ_l_r;
    integ_r_nxt  = integ_r_r;
    tick_nxt     = tick_r;
    halted_nxt   = halted_r;
    period_l_nxt = period_l_r;
    period_r_nxt = period_r_r;
    last_l_nxt   = last_l_r;
    last_r_nxt   = last_r_r;
    tgt_l_nxt    = tgt_l_r;
    tgt_r_nxt    = tgt_r_r;
    gain_nxt     = gain_r;
    init_nxt     = init_r;
    dmin_nxt     = dmin_r;
    dmax_nxt     = dmax_r;
    limit_nxt    = limit_r;
    out_valid_nxt = out_valid_r;
    o_duty_l_nxt = o_duty_l_r;
    o_duty_r_nxt = o_duty_r_r;
    o_spd_l_nxt  = o_spd_l_r;
    o_spd_r_nxt  = o_spd_r_r;
    o_stop_nxt   = o_stop_r;

    // The receiver takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_TARGET_LEFT:  tgt_l_nxt = cfg_wdata;
        CFG_TARGET_RIGHT: tgt_r_nxt = cfg_wdata;
        CFG_LOOP_GAIN:    gain_nxt  = cfg_wdata;
        CFG_INITIAL_DUTY: begin
          init_nxt    = cfg_wdata[DUTY_W-1:0];
          integ_l_nxt = cfg_wdata[DUTY_W-1:0];
          integ_r_nxt = cfg_wdata[DUTY_W-1:0];
        end
        CFG_DUTY_MIN:     dmin_nxt  = cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_MAX:     dmax_nxt  = cfg_wdata[DUTY_W-1:0];
        CFG_RUN_LIMIT:    limit_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_RIGHT_EDGE: begin
              period_r_nxt = in_edge_time - last_r_r;
              last_r_nxt   = in_edge_time;
            end
            REQ_LEFT_EDGE: begin
              period_l_nxt = in_edge_time - last_l_r;
              last_l_nxt   = in_edge_time;
            end
            REQ_TICK: begin
              bump_nxt  = in_bump;
              sel_nxt   = 1'b0;
              state_nxt = ST_DLOAD;
            end
            default: ;
          endcase
        end
      end

      // Load the divider; a zero period keeps the numerator as the speed.
      ST_DLOAD: begin
        q_nxt   = NUM_VAL;
        rem_nxt = '0;
        cnt_nxt = '0;
        dvs_nxt = sel_r ? period_r_r : period_l_r;
        if ((sel_r ? period_r_r : period_l_r) == '0) begin
          state_nxt = ST_SPD;
        end else begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
        q_nxt   = NW'({q_r, div_ge});
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SPD;
        end
      end

      // Store the speed, set up the multiplier on the error magnitude, or skip it when stopped.
      ST_SPD: begin
        if (sel_r) begin
          speed_r_nxt = spd_sat;
        end else begin
          speed_l_nxt = spd_sat;
        end
        neg_nxt  = err_neg;
        mag_nxt  = err_neg ? (spd_sat - tgt_ext) : (tgt_ext - spd_sat);
        prod_nxt = PROD_W'(gain_r);
        cnt_nxt  = '0;
        if (!halted_r) begin
          state_nxt = ST_MUL;
        end else if (sel_r) begin
          state_nxt = ST_OUT;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = ST_DLOAD;
        end
      end

      ST_MUL: begin
        prod_nxt = {mul_sum, prod_r[GAIN_W-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_UPD;
        end
      end

      // Write the clamped integrator; the right wheel pass closes the tick.
      ST_UPD: begin
        if (sel_r) begin
          integ_r_nxt = u_clamp;
          tick_nxt    = tick_inc;
          halted_nxt  = (tick_inc == limit_r) || bump_r;
          state_nxt   = ST_OUT;
        end else begin
          integ_l_nxt = u_clamp;
          sel_nxt     = 1'b1;
          state_nxt   = ST_DLOAD;
        end
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_duty_l_nxt  = halted_r ? '0 : integ_l_r;
          o_duty_r_nxt  = halted_r ? '0 : integ_r_r;
          o_spd_l_nxt   = speed_l_r;
          o_spd_r_nxt   = speed_r_r;
          o_stop_nxt    = halted_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      halted_r    <= 1'b0;
      period_l_r  <= '0;
      period_r_r  <= '0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      integ_l_r   <= INITIAL_DUTY_RST;
      integ_r_r   <= INITIAL_DUTY_RST;
      tgt_l_r     <= TARGET_RST;
      tgt_r_r     <= TARGET_RST;
      gain_r      <= LOOP_GAIN_RST;
      init_r      <= INITIAL_DUTY_RST;
      dmin_r      <= DUTY_MIN_RST;
      dmax_r      <= DUTY_MAX_RST;
      limit_r     <= RUN_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      halted_r    <= halted_nxt;
      period_l_r  <= period_l_nxt;
      period_r_r  <= period_r_nxt;
      last_l_r    <= last_l_nxt;
      last_r_r    <= last_r_nxt;
      integ_l_r   <= integ_l_nxt;
      integ_r_r   <= integ_r_nxt;
      tgt_l_r     <= tgt_l_nxt;
      tgt_r_r     <= tgt_r_nxt;
      gain_r      <= gain_nxt;
      init_r      <= init_nxt;
      dmin_r      <= dmin_nxt;
      dmax_r      <= dmax_nxt;
      limit_r     <= limit_nxt;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    bump_r     <= bump_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    prod_r     <= prod_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    speed_l_r  <= speed_l_nxt;
    speed_r_r  <= speed_r_nxt;
    o_duty_l_r <= o_duty_l_nxt;
    o_duty_r_r <= o_duty_r_nxt;
    o_spd_l_r  <= o_spd_l_nxt;
    o_spd_r_r  <= o_spd_r_nxt;
    o_stop_r   <= o_stop_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_duty_left   = o_duty_l_r;
  assign out_duty_right  = o_duty_r_r;
  assign out_speed_left  = o_spd_l_r;
  assign out_speed_right = o_spd_r_r;
  assign out_stopped     = o_stop_r;

endmodule
